// ===== rtl/core/upd_pkg.sv =====
package upd_pkg;

  localparam int unsigned ECHO_W   = 15;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DIST_W   = 9;
  localparam int unsigned TRIG_W   = 9;
  localparam int unsigned DEB_W    = 8;
  localparam int unsigned POLL_W   = 16;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W   = TIME_W + POLL_W;

  localparam logic [ECHO_W-1:0] ECHO_MIN_US = ECHO_W'(116);
  localparam logic [ECHO_W-1:0] ECHO_MAX_US = ECHO_W'(23200);

  // floor(x / 58) == (x * 36158) >> 21 for every x below 174762
  localparam int unsigned DIV58_MUL_W = 16;
  localparam int unsigned DIV58_PROD_W = ECHO_W + DIV58_MUL_W;
  localparam logic [DIV58_MUL_W-1:0] DIV58_MUL = DIV58_MUL_W'(36158);
  localparam int unsigned DIV58_SHIFT = 21;

  localparam logic [TRIG_W-1:0] TRIGGER_RST = TRIG_W'(50);
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = DEB_W'(3);
  localparam logic [POLL_W-1:0] POLL_RST = POLL_W'(200);
  localparam logic [TIME_W-1:0] FAULT_RST = TIME_W'(150000);
  localparam logic [TIME_W-1:0] WARN_RST = TIME_W'(30000);

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_POLL     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_WARN     = CFG_IDX_W'(4);

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int unsigned WIN_DEPTH = 3;
  localparam int unsigned WIN_SLOT_W = 2;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_DETECT = 2'd1,
    EV_CLEAR  = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic              sample_ok;
    logic [DIST_W-1:0] raw_cm;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic              valid;
    item_t             item;
  } push_t;

endpackage

// ===== rtl/core/upd_front.sv =====
module upd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [upd_pkg::ECHO_W-1:0]   echo_us,
  input  logic [upd_pkg::TIME_W-1:0]   now_ms,
  output upd_pkg::push_t               push,
  input  logic                         q_ready
);

  logic                            f_valid;
  upd_pkg::item_t                  f_item;
  logic [upd_pkg::DIV58_PROD_W-1:0] cm_prod;
  logic                            echo_ok;
  logic                            take;

  assign echo_ok = (echo_us >= upd_pkg::ECHO_MIN_US) && (echo_us <= upd_pkg::ECHO_MAX_US);
  assign cm_prod = upd_pkg::DIV58_PROD_W'(echo_us) * upd_pkg::DIV58_PROD_W'(upd_pkg::DIV58_MUL);

  assign in_ready = !f_valid || q_ready;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (q_ready) begin
      f_valid <= 1'b0;
    end
    if (take) begin
      f_item.sample_ok <= echo_ok;
      f_item.raw_cm    <= upd_pkg::DIST_W'(cm_prod >> upd_pkg::DIV58_SHIFT);
      f_item.now_ms    <= now_ms;
    end
  end

  assign push.valid = f_valid;
  assign push.item  = f_item;

endmodule

// ===== rtl/core/upd_queue.sv =====
module upd_queue (
  input  logic           clk,
  input  logic           rst,
  input  upd_pkg::push_t push,
  output logic           q_ready,
  output logic           head_valid,
  output upd_pkg::item_t head,
  input  logic           pop
);

  upd_pkg::item_t                 slots [upd_pkg::Q_DEPTH];
  logic [upd_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [upd_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [upd_pkg::Q_CNT_W-1:0]    count;
  logic                           do_push;
  logic                           do_pop;

  assign q_ready    = (count != upd_pkg::Q_CNT_W'(upd_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push.valid && q_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == upd_pkg::Q_PTR_W'(upd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == upd_pkg::Q_PTR_W'(upd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push.item;
    end
  end

endmodule

// ===== rtl/core/upd_back.sv =====
module upd_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [upd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [upd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            head_valid,
  input  upd_pkg::item_t                  head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            sample_valid,
  output logic [upd_pkg::DIST_W-1:0]      distance_cm,
  output logic                            obstacle_present,
  output logic [1:0]                      event_kind,
  output logic [upd_pkg::DIST_W-1:0]      event_distance_cm,
  output logic [upd_pkg::TIME_W-1:0]      event_duration_ms,
  output logic                            fault_pulse,
  output logic                            no_echo_warning
);

  logic [upd_pkg::TRIG_W-1:0] trigger_cm;
  logic [upd_pkg::DEB_W-1:0]  debounce_count;
  logic [upd_pkg::POLL_W-1:0] poll_interval_ms;
  logic [upd_pkg::TIME_W-1:0] fault_after_ms;
  logic [upd_pkg::TIME_W-1:0] warn_after_ms;

  logic [upd_pkg::DIST_W-1:0]     win [upd_pkg::WIN_DEPTH];
  logic [upd_pkg::WIN_DEPTH-1:0]  win_valid;
  logic [upd_pkg::WIN_SLOT_W-1:0] wslot;
  logic [upd_pkg::TIME_W-1:0]     streak;
  logic [upd_pkg::PROD_W-1:0]     streak_time;
  logic                           fault_reported;
  logic [upd_pkg::TIME_W-1:0]     no_echo_time;
  logic [upd_pkg::DEB_W-1:0]      below_run;
  logic [upd_pkg::DEB_W-1:0]      above_run;
  logic                           passage_active;
  logic [upd_pkg::TIME_W-1:0]     passage_start;
  logic [upd_pkg::DIST_W-1:0]     latched_dist;
  logic                           present;

  logic                           streak_max;
  logic [upd_pkg::TIME_W-1:0]     streak_next;
  logic [upd_pkg::PROD_W-1:0]     streak_time_next;
  logic                           fault_hit;
  logic [upd_pkg::TIME_W:0]       time_sum;
  logic [upd_pkg::TIME_W-1:0]     time_sat;
  logic                           warn_hit;

  logic [upd_pkg::DIST_W-1:0]     w [upd_pkg::WIN_DEPTH];
  logic [upd_pkg::WIN_DEPTH-1:0]  wv;
  logic [upd_pkg::DIST_W-1:0]     filt_cm;
  logic                           below;
  logic [upd_pkg::DEB_W-1:0]      below_inc;
  logic [upd_pkg::DEB_W-1:0]      above_inc;
  logic                           detect;
  logic                           clear;
  logic [upd_pkg::WIN_SLOT_W-1:0] slot_next;

  function automatic logic [upd_pkg::DIST_W-1:0] med3(
    input logic [upd_pkg::DIST_W-1:0] x,
    input logic [upd_pkg::DIST_W-1:0] y,
    input logic [upd_pkg::DIST_W-1:0] z
  );
    if ((x <= y && y <= z) || (z <= y && y <= x)) begin
      return y;
    end else if ((y <= x && x <= z) || (z <= x && x <= y)) begin
      return x;
    end
    return z;
  endfunction

  assign pop = head_valid && (!out_valid || out_ready);

  // no-echo path
  assign streak_max = (streak == '1);
  assign streak_next = streak_max ? streak : streak + 1'b1;
  assign streak_time_next = streak_max ? streak_time
                                       : streak_time + upd_pkg::PROD_W'(poll_interval_ms);
  assign fault_hit = !fault_reported && (streak_time_next >= upd_pkg::PROD_W'(fault_after_ms));
  assign time_sum = {1'b0, no_echo_time} + (upd_pkg::TIME_W + 1)'(poll_interval_ms);
  assign time_sat = time_sum[upd_pkg::TIME_W] ? '1 : time_sum[upd_pkg::TIME_W-1:0];
  assign warn_hit = (time_sat >= warn_after_ms);

  // valid-sample path
  always_comb begin
    for (int i = 0; i < upd_pkg::WIN_DEPTH; i++) begin
      w[i]  = (wslot == upd_pkg::WIN_SLOT_W'(i)) ? head.raw_cm : win[i];
      wv[i] = (wslot == upd_pkg::WIN_SLOT_W'(i)) || win_valid[i];
    end
  end

  assign filt_cm = (&wv) ? med3(w[0], w[1], w[2]) : head.raw_cm;
  assign below = (filt_cm < trigger_cm);
  assign below_inc = (below_run == '1) ? below_run : below_run + 1'b1;
  assign above_inc = (above_run == '1) ? above_run : above_run + 1'b1;
  assign detect = below && !passage_active && (below_inc >= debounce_count);
  assign clear = !below && passage_active && (above_inc >= debounce_count);
  assign slot_next = (wslot == upd_pkg::WIN_SLOT_W'(upd_pkg::WIN_DEPTH - 1))
                   ? '0 : wslot + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_cm       <= upd_pkg::TRIGGER_RST;
      debounce_count   <= upd_pkg::DEBOUNCE_RST;
      poll_interval_ms <= upd_pkg::POLL_RST;
      fault_after_ms   <= upd_pkg::FAULT_RST;
      warn_after_ms    <= upd_pkg::WARN_RST;
      win_valid        <= '0;
      wslot            <= '0;
      streak           <= '0;
      streak_time      <= '0;
      fault_reported   <= 1'b0;
      no_echo_time     <= '0;
      below_run        <= '0;
      above_run        <= '0;
      passage_active   <= 1'b0;
      passage_start    <= '0;
      latched_dist     <= '0;
      present          <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          upd_pkg::CFG_TRIGGER:  trigger_cm <= cfg_data[upd_pkg::TRIG_W-1:0];
          upd_pkg::CFG_DEBOUNCE: debounce_count <= cfg_data[upd_pkg::DEB_W-1:0];
          upd_pkg::CFG_POLL: begin
            poll_interval_ms <= cfg_data[upd_pkg::POLL_W-1:0];
            streak_time <= upd_pkg::PROD_W'(streak) *
                           upd_pkg::PROD_W'(cfg_data[upd_pkg::POLL_W-1:0]);
          end
          upd_pkg::CFG_FAULT:    fault_after_ms <= cfg_data[upd_pkg::TIME_W-1:0];
          upd_pkg::CFG_WARN:     warn_after_ms <= cfg_data[upd_pkg::TIME_W-1:0];
          default: ;
        endcase
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop && !head.sample_ok) begin
        streak       <= streak_next;
        streak_time  <= streak_time_next;
        no_echo_time <= warn_hit ? '0 : time_sat;
        if (fault_hit) begin
          fault_reported <= 1'b1;
        end
      end else if (pop) begin
        streak         <= '0;
        streak_time    <= '0;
        fault_reported <= 1'b0;
        no_echo_time   <= '0;
        win_valid      <= wv;
        wslot          <= slot_next;
        present        <= (filt_cm != '0) && below;
        if (below) begin
          below_run <= below_inc;
          above_run <= '0;
        end else begin
          above_run <= above_inc;
          below_run <= '0;
        end
        if (detect) begin
          passage_active <= 1'b1;
          passage_start  <= head.now_ms;
          latched_dist   <= filt_cm;
        end else if (clear) begin
          passage_active <= 1'b0;
        end
      end
    end
    if (pop) begin
      for (int i = 0; i < upd_pkg::WIN_DEPTH; i++) begin
        if (head.sample_ok) begin
          win[i] <= w[i];
        end
      end
      sample_valid     <= head.sample_ok;
      distance_cm      <= head.sample_ok ? filt_cm : '0;
      obstacle_present <= head.sample_ok ? ((filt_cm != '0) && below) : present;
      fault_pulse      <= !head.sample_ok && fault_hit;
      no_echo_warning  <= !head.sample_ok && warn_hit;
      if (head.sample_ok && detect) begin
        event_kind        <= upd_pkg::EV_DETECT;
        event_distance_cm <= filt_cm;
        event_duration_ms <= '0;
      end else if (head.sample_ok && clear) begin
        event_kind        <= upd_pkg::EV_CLEAR;
        event_distance_cm <= latched_dist;
        event_duration_ms <= head.now_ms - passage_start;
      end else begin
        event_kind        <= upd_pkg::EV_NONE;
        event_distance_cm <= '0;
        event_duration_ms <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    wslot != 2'd3)
    else $error("window slot out of range");

  a_streak_time: assert property (@(posedge clk) disable iff (rst)
    streak_time == upd_pkg::PROD_W'(streak) * upd_pkg::PROD_W'(poll_interval_ms))
    else $error("streak time out of step with streak and poll interval");

  a_detect_sets: assert property (@(posedge clk) disable iff (rst)
    pop && head.sample_ok && detect |=> passage_active && out_valid
      && event_kind == upd_pkg::EV_DETECT)
    else $error("detect edge did not enter passage");

  a_fault_once: assert property (@(posedge clk) disable iff (rst)
    pop && !head.sample_ok && fault_hit |=> fault_reported && fault_pulse)
    else $error("fault not recorded");

  a_noecho_result: assert property (@(posedge clk) disable iff (rst)
    pop && !head.sample_ok |=> !sample_valid && distance_cm == '0
      && event_kind == upd_pkg::EV_NONE)
    else $error("no-echo poll produced a sample or event");
`endif

endmodule

// ===== rtl/core/ultrasonic_passage_detector.sv =====
// channel   | handshake               | payload
// ----------+-------------------------+---------------------------------------------
// input     | in_valid / in_ready     | echo_us, now_ms
// result    | out_valid / out_ready   | sample_valid, distance_cm, obstacle_present,
//           |                         | event_kind, event_distance_cm,
//           |                         | event_duration_ms, fault_pulse, no_echo_warning
// config    | cfg_write               | cfg_index, cfg_data
//
// One poll per cycle sustained while out_ready stays high; out_valid rises once the input
// transfer has passed the front register, a queue entry and the output register.
// The front register holds the echo validity test and the divide-by-58 multiply.
// rst is synchronous; no clearing pass, the window valid bits reset at once.
// out_ready low fills the output register, then the queue, then the front register,
// and only then drops in_ready.
module ultrasonic_passage_detector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [upd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [upd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [upd_pkg::ECHO_W-1:0]      echo_us,
  input  logic [upd_pkg::TIME_W-1:0]      now_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            sample_valid,
  output logic [upd_pkg::DIST_W-1:0]      distance_cm,
  output logic                            obstacle_present,
  output logic [1:0]                      event_kind,
  output logic [upd_pkg::DIST_W-1:0]      event_distance_cm,
  output logic [upd_pkg::TIME_W-1:0]      event_duration_ms,
  output logic                            fault_pulse,
  output logic                            no_echo_warning
);

  upd_pkg::push_t push;
  logic           q_ready;
  logic           head_valid;
  upd_pkg::item_t head;
  logic           pop;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .echo_us  (echo_us),
    .now_ms   (now_ms),
    .push     (push),
    .q_ready  (q_ready)
  );

  upd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .q_ready    (q_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  upd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .sample_valid      (sample_valid),
    .distance_cm       (distance_cm),
    .obstacle_present  (obstacle_present),
    .event_kind        (event_kind),
    .event_distance_cm (event_distance_cm),
    .event_duration_ms (event_duration_ms),
    .fault_pulse       (fault_pulse),
    .no_echo_warning   (no_echo_warning)
  );

endmodule

// ===== verif/tb_ultrasonic_passage_detector.sv =====
`timescale 1ns / 100ps

module tb_ultrasonic_passage_detector;

  localparam logic [upd_pkg::ECHO_W-1:0] ECHO_SHORTEST = upd_pkg::ECHO_W'(116);
  localparam logic [upd_pkg::ECHO_W-1:0] ECHO_LONGEST  = upd_pkg::ECHO_W'(23200);
  localparam int unsigned       US_PER_CM     = 58;
  localparam logic [upd_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = upd_pkg::CFG_IDX_W'(5);
  localparam logic [upd_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = upd_pkg::CFG_IDX_W'(7);

  typedef struct packed {
    logic [upd_pkg::ECHO_W-1:0] echo;
    logic [upd_pkg::TIME_W-1:0] stamp;
  } poll_t;

  typedef struct packed {
    logic                       sample_valid;
    logic [upd_pkg::DIST_W-1:0] cm;
    logic                       present;
    upd_pkg::event_kind_t       kind;
    logic [upd_pkg::DIST_W-1:0] ev_dist;
    logic [upd_pkg::TIME_W-1:0] ev_dur;
    logic                       fault;
    logic                       warn;
  } poll_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [upd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [upd_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [upd_pkg::ECHO_W-1:0]    echo_us = '0;
  logic [upd_pkg::TIME_W-1:0]    now_ms = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          sample_valid;
  logic [upd_pkg::DIST_W-1:0]    distance_cm;
  logic                          obstacle_present;
  logic [1:0]                    event_kind;
  logic [upd_pkg::DIST_W-1:0]    event_distance_cm;
  logic [upd_pkg::TIME_W-1:0]    event_duration_ms;
  logic                          fault_pulse;
  logic                          no_echo_warning;

  ultrasonic_passage_detector dut (.*);

  always #2 clk = ~clk;

  // predictor configuration
  logic [upd_pkg::TRIG_W-1:0] trig_cm  = upd_pkg::TRIGGER_RST;
  logic [upd_pkg::DEB_W-1:0]  deb_cnt  = upd_pkg::DEBOUNCE_RST;
  logic [upd_pkg::POLL_W-1:0] poll_ms  = upd_pkg::POLL_RST;
  logic [upd_pkg::TIME_W-1:0] fault_ms = upd_pkg::FAULT_RST;
  logic [upd_pkg::TIME_W-1:0] warn_ms  = upd_pkg::WARN_RST;

  // predictor state
  logic [upd_pkg::DIST_W-1:0] win_cm [upd_pkg::WIN_DEPTH] = '{default: '0};
  logic                       win_full [upd_pkg::WIN_DEPTH] = '{default: 1'b0};
  logic [1:0]                 win_slot = '0;
  logic [upd_pkg::TIME_W-1:0] silent_polls = '0;
  logic                       fault_flagged = 1'b0;
  logic [upd_pkg::TIME_W-1:0] silent_ms = '0;
  logic [7:0]                 below_cnt = '0;
  logic [7:0]                 above_cnt = '0;
  logic                       passage_open = 1'b0;
  logic [upd_pkg::TIME_W-1:0] passage_t0 = '0;
  logic [upd_pkg::DIST_W-1:0] passage_cm = '0;
  logic                       present_now = 1'b0;

  poll_t        polls_to_send[$];
  poll_result_t poll_results_due[$];
  int           mismatches = 0;
  bit           send_idle_on = 1'b1;
  bit           recv_idle_on = 1'b1;
  int           gap_left = 0;
  int           stall_left = 0;
  logic [upd_pkg::TIME_W-1:0] poll_clock_ms = '0;

  function automatic logic [upd_pkg::DIST_W-1:0] mid3(input logic [upd_pkg::DIST_W-1:0] a, b,
                                                      c);
    logic [upd_pkg::DIST_W-1:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (c < lo) ? lo : ((c > hi) ? hi : c);
  endfunction

  function automatic poll_result_t predict_poll(input logic [upd_pkg::ECHO_W-1:0] echo,
                                                input logic [upd_pkg::TIME_W-1:0] stamp);
    poll_result_t r;
    logic [upd_pkg::TIME_W:0]                   sum;
    logic [upd_pkg::TIME_W+upd_pkg::POLL_W-1:0] prod;
    logic [upd_pkg::DIST_W-1:0]                 raw, d;
    r = '0;
    r.kind = upd_pkg::EV_NONE;
    if (echo < ECHO_SHORTEST || echo > ECHO_LONGEST) begin
      if (silent_polls != '1) silent_polls++;
      prod = silent_polls * poll_ms;
      if (!fault_flagged && prod >= fault_ms) begin
        fault_flagged = 1'b1;
        r.fault = 1'b1;
      end
      sum = silent_ms + poll_ms;
      if (sum > {1'b0, {upd_pkg::TIME_W{1'b1}}}) sum = {1'b0, {upd_pkg::TIME_W{1'b1}}};
      silent_ms = sum[upd_pkg::TIME_W-1:0];
      if (silent_ms >= warn_ms) begin
        r.warn = 1'b1;
        silent_ms = '0;
      end
    end else begin
      raw = upd_pkg::DIST_W'(echo / US_PER_CM);
      silent_polls = '0;
      fault_flagged = 1'b0;
      silent_ms = '0;
      win_cm[win_slot] = raw;
      win_full[win_slot] = 1'b1;
      win_slot = (win_slot == 2'd2) ? 2'd0 : win_slot + 2'd1;
      d = (win_full[0] && win_full[1] && win_full[2]) ?
          mid3(win_cm[0], win_cm[1], win_cm[2]) : raw;
      r.sample_valid = 1'b1;
      r.cm = d;
      present_now = (d != 0) && (d < trig_cm);
      if (d < trig_cm) begin
        if (below_cnt != 8'hFF) below_cnt++;
        above_cnt = '0;
        if (!passage_open && below_cnt >= deb_cnt) begin
          passage_open = 1'b1;
          passage_t0 = stamp;
          passage_cm = d;
          r.kind = upd_pkg::EV_DETECT;
          r.ev_dist = d;
        end
      end else begin
        if (above_cnt != 8'hFF) above_cnt++;
        below_cnt = '0;
        if (passage_open && above_cnt >= deb_cnt) begin
          passage_open = 1'b0;
          r.kind = upd_pkg::EV_CLEAR;
          r.ev_dist = passage_cm;
          r.ev_dur = stamp - passage_t0;
        end
      end
    end
    r.present = present_now;
    return r;
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender
  always @(posedge clk) begin : poll_driver
    poll_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) poll_results_due.push_back(predict_poll(echo_us, now_ms));
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (polls_to_send.size() != 0) begin
          p = polls_to_send.pop_front();
          echo_us <= p.echo;
          now_ms <= p.stamp;
          in_valid <= 1'b1;
          gap_left = send_idle_on ? pick_pause() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin : result_sink
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left != 0) stall_left--;
      else if (recv_idle_on) stall_left = pick_pause();
      out_ready <= (stall_left == 0);
    end
  end

  task automatic check_field(input string name, input logic [upd_pkg::TIME_W-1:0] want,
                             input logic [upd_pkg::TIME_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    poll_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (poll_results_due.size() == 0) begin
        mismatches++;
        $display("%0t result transfer with nothing expected", $time);
      end else begin
        want = poll_results_due.pop_front();
        check_field("sample_valid", want.sample_valid, sample_valid);
        check_field("distance_cm", want.cm, distance_cm);
        check_field("obstacle_present", want.present, obstacle_present);
        check_field("event_kind", want.kind, event_kind);
        check_field("event_distance_cm", want.ev_dist, event_distance_cm);
        check_field("event_duration_ms", want.ev_dur, event_duration_ms);
        check_field("fault_pulse", want.fault, fault_pulse);
        check_field("no_echo_warning", want.warn, no_echo_warning);
      end
    end
  end

  task automatic write_reg(input logic [upd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [upd_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      upd_pkg::CFG_TRIGGER:  trig_cm = val[upd_pkg::TRIG_W-1:0];
      upd_pkg::CFG_DEBOUNCE: deb_cnt = val[upd_pkg::DEB_W-1:0];
      upd_pkg::CFG_POLL:     poll_ms = val[upd_pkg::POLL_W-1:0];
      upd_pkg::CFG_FAULT:    fault_ms = val;
      upd_pkg::CFG_WARN:     warn_ms = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (polls_to_send.size() != 0 || in_valid || poll_results_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_poll(input logic [upd_pkg::ECHO_W-1:0] echo,
                            input logic [upd_pkg::TIME_W-1:0] stamp);
    polls_to_send.push_back('{echo: echo, stamp: stamp});
  endtask

  function automatic logic [upd_pkg::TIME_W-1:0] next_stamp();
    poll_clock_ms += ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(0, 400);
    return poll_clock_ms;
  endfunction

  function automatic logic [upd_pkg::ECHO_W-1:0] echo_for_cm(input int cm);
    int e;
    e = cm * US_PER_CM + $urandom_range(0, US_PER_CM - 1);
    return (e > ECHO_LONGEST) ? ECHO_LONGEST : upd_pkg::ECHO_W'(e);
  endfunction

  function automatic logic [upd_pkg::ECHO_W-1:0] silent_echo();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return upd_pkg::ECHO_W'($urandom_range(1, ECHO_SHORTEST - 1));
      2: return upd_pkg::ECHO_W'($urandom_range(ECHO_LONGEST + 1, 30000));
      default: return upd_pkg::ECHO_W'($urandom_range(ECHO_LONGEST + 1, 32767));
    endcase
  endfunction

  // runs below and above the trigger long enough to confirm edges,
  // with no-echo stretches and junk in between
  task automatic run_random(input int budget);
    int n, len, seg, i, hi, lo;
    logic [upd_pkg::ECHO_W-1:0] e;
    n = 0;
    while (n < budget) begin
      seg = $urandom_range(0, 9);
      if (seg < 4 && trig_cm < 3) seg = 4;
      if (seg >= 4 && seg < 8 && trig_cm > 400) seg = 0;
      if (seg < 8)
        len = (deb_cnt > 12) ? $urandom_range(deb_cnt - 4, deb_cnt + 8)
                             : $urandom_range(1, deb_cnt + 4);
      else if (seg == 8)
        len = $urandom_range(1, 30);
      else
        len = $urandom_range(1, 4);
      hi = (trig_cm > 400) ? 400 : trig_cm - 1;
      lo = (trig_cm < 2) ? 2 : trig_cm;
      for (i = 0; i < len; i++) begin
        if (seg < 4) e = echo_for_cm($urandom_range(2, hi));
        else if (seg < 8) e = echo_for_cm($urandom_range(lo, 400));
        else if (seg == 8) e = silent_echo();
        else e = upd_pkg::ECHO_W'($urandom_range(0, 32767));
        if (seg < 8 && $urandom_range(0, 15) == 0)
          e = upd_pkg::ECHO_W'($urandom_range(ECHO_SHORTEST, ECHO_LONGEST));
        queue_poll(e, next_stamp());
      end
      n += len;
    end
  endtask

  initial begin : stimulus
    logic [upd_pkg::TIME_W-1:0] k;
    int p;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset configuration: window fill, echo limits, detect, stamp wrap
    queue_poll(15'd0, 32'd0);
    queue_poll(15'd115, 32'd100);
    queue_poll(15'd116, 32'd200);
    queue_poll(15'd117, 32'd300);
    queue_poll(15'd23200, 32'd400);
    queue_poll(15'd23201, 32'd500);
    queue_poll(15'd32767, 32'd600);
    queue_poll(15'd2900, 32'd700);
    queue_poll(15'd2899, 32'd800);
    queue_poll(15'd580, 32'hFFFF_FF00);
    queue_poll(15'd637, 32'hFFFF_FFFF);
    queue_poll(15'd1000, 32'h0000_0050);
    queue_poll(15'd20000, 32'h0000_0100);
    queue_poll(15'd20000, 32'h0000_0200);
    queue_poll(15'd21000, 32'h0000_0300);
    queue_poll(15'd30000, 32'h0000_0400);
    wait_drained();

    // zero trigger and debounce, fault and warning on the same poll
    write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(upd_pkg::CFG_TRIGGER, 32'd0);
    write_reg(upd_pkg::CFG_DEBOUNCE, 32'd0);
    write_reg(upd_pkg::CFG_POLL, 32'd1);
    write_reg(upd_pkg::CFG_FAULT, 32'd1);
    write_reg(upd_pkg::CFG_WARN, 32'd1);
    @(negedge clk);
    queue_poll(15'd0, 32'd10);
    queue_poll(15'd0, 32'd20);
    queue_poll(15'd5800, 32'd30);
    queue_poll(15'd116, 32'd40);
    queue_poll(15'd23200, 32'd50);
    queue_poll(15'd100, 32'd60);
    wait_drained();

    for (p = 0; p < 8; p++) begin
      send_idle_on = (p % 3 != 1);
      recv_idle_on = (p % 4 != 2);
      write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
      case (p)
        0: write_reg(upd_pkg::CFG_TRIGGER, 32'd1);
        1: write_reg(upd_pkg::CFG_TRIGGER, 32'd400);
        2: write_reg(upd_pkg::CFG_TRIGGER, 32'd511);
        3: write_reg(upd_pkg::CFG_TRIGGER, 32'd0);
        default: write_reg(upd_pkg::CFG_TRIGGER, $urandom_range(10, 400));
      endcase
      case (p)
        4: write_reg(upd_pkg::CFG_DEBOUNCE, 32'd255);
        5: write_reg(upd_pkg::CFG_DEBOUNCE, 32'd0);
        6: write_reg(upd_pkg::CFG_DEBOUNCE, 32'd1);
        default: write_reg(upd_pkg::CFG_DEBOUNCE, $urandom_range(1, 6));
      endcase
      case (p)
        1: write_reg(upd_pkg::CFG_POLL, 32'd65535);
        2: write_reg(upd_pkg::CFG_POLL, 32'd1);
        default: write_reg(upd_pkg::CFG_POLL, $urandom_range(1, 1000));
      endcase
      k = poll_ms;
      case (p)
        3: write_reg(upd_pkg::CFG_FAULT, 32'hFFFF_FFFF);
        6: write_reg(upd_pkg::CFG_FAULT, 32'd1);
        default: write_reg(upd_pkg::CFG_FAULT, k * $urandom_range(1, 30));
      endcase
      case (p)
        1: write_reg(upd_pkg::CFG_WARN, 32'hFFFF_FFFF);
        5: write_reg(upd_pkg::CFG_WARN, 32'd1);
        default: write_reg(upd_pkg::CFG_WARN, k * $urandom_range(1, 20));
      endcase
      @(negedge clk);
      run_random((p == 4) ? 600 : 150);
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_ultrasonic_passage_detector OK");
    end else begin
      $display("tb_ultrasonic_passage_detector NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("tb_ultrasonic_passage_detector NOT OK");
    $finish;
  end

endmodule
